FILE: rtl/cts_pkg.sv
package cts_pkg;

    localparam int WORD_W = 29;
    localparam int LINE_W = 28;
    localparam int ADDR_W = 32;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0] CFG_POLICY  = 2'd0;
    localparam logic [1:0] CFG_L1_BITS = 2'd1;
    localparam logic [1:0] CFG_L2_BITS = 2'd2;

    localparam logic [3:0] L1_BITS_RESET = 4'd8;
    localparam logic [3:0] L2_BITS_RESET = 4'd8;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_MARK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CACHE_L1I = 2'd0,
        CACHE_L2  = 2'd1,
        CACHE_L1D = 2'd2
    } cache_t;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_EXEC  = 2'd1,
        B_CLEAR = 2'd2
    } back_state_t;

    typedef struct packed {
        logic       policy;
        logic [3:0] l1_bits;
        logic [3:0] l2_bits;
    } cfg_t;

    typedef struct packed {
        cmd_t              cmd;
        cache_t            cache;
        logic [WORD_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] block_out;
        logic              evicted;
    } res_t;

endpackage

FILE: rtl/cache_tag_store_lru_top.sv
// Tag store for an L1 instruction cache, an L1 data cache (both direct
// mapped) and a set-associative L2, entries kept oldest first in each set.
// Command channel: queue style, push/full. A transfer happens when push is
// high and full is low. Result channel: empty/pop, the oldest result sits
// on found, block_out and evicted while empty is low and is taken on pop.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Write only while no command is in flight.
// Path: a transferred command waits in the command queue; the back-end
// sequencer takes it in its idle state while the result queue is not full,
// reading the set from memory, then in its exec state compares, reorders,
// writes back and pushes the result. It takes no new command until done.
// A two-entry command queue parts the classifying front end from the back
// end; a two-entry result queue parts the back end from the receiver. When
// the receiver stalls, the result queue fills, the back end halts and the
// command queue fills up until full rises.
// Reset loads the LFSR seed and the configuration defaults, then the back
// end clears valid bits and fill counts in all 2^MAX_INDEX_BITS sets (256
// by default) of the set memories; commands queue up meanwhile.
module cache_tag_store_lru_top
    import cts_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 8,
    parameter int L2_WAYS        = 4,
    parameter int LINE_SHIFT     = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        cmd,
    input  logic [1:0]        cache_sel,
    input  logic [ADDR_W-1:0] address,
    input  logic [WORD_W-1:0] block_in,
    output logic              empty,
    input  logic              pop,
    output logic              found,
    output logic [WORD_W-1:0] block_out,
    output logic              evicted,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [3:0]        cfg_data
);

    localparam int QW = $bits(item_t) + MAX_INDEX_BITS;

    cfg_t                      cfg_reg;
    item_t                     f_item;
    logic [MAX_INDEX_BITS-1:0] f_set;
    logic [QW-1:0]             q_dout;
    item_t                     q_item;
    logic [MAX_INDEX_BITS-1:0] q_set;
    logic                      q_empty;
    logic                      q_pop;
    logic                      res_full;
    logic                      res_push;
    res_t                      res_in;
    res_t                      res_out;

    assign cfg_ready = 1'b1;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy  <= 1'b0;
            cfg_reg.l1_bits <= L1_BITS_RESET;
            cfg_reg.l2_bits <= L2_BITS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POLICY:  cfg_reg.policy  <= cfg_data[0];
                CFG_L1_BITS: cfg_reg.l1_bits <= cfg_data;
                CFG_L2_BITS: cfg_reg.l2_bits <= cfg_data;
                default:     cfg_reg.policy  <= cfg_reg.policy;
            endcase
        end
    end

    cts_front #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .LINE_SHIFT     (LINE_SHIFT)
    ) u_front (
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cache_sel (cache_sel),
        .address   (address),
        .block_in  (block_in),
        .item      (f_item),
        .set_idx   (f_set)
    );

    cts_fifo #(
        .W (QW)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .din   ({f_item, f_set}),
        .dout  (q_dout),
        .full  (full),
        .empty (q_empty)
    );

    assign {q_item, q_set} = q_dout;

    cts_back #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .L2_WAYS        (L2_WAYS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_set    (q_set),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    cts_fifo #(
        .W ($bits(res_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .pop   (pop),
        .din   (res_in),
        .dout  (res_out),
        .full  (res_full),
        .empty (empty)
    );

    assign found     = res_out.found;
    assign block_out = res_out.block_out;
    assign evicted   = res_out.evicted;

endmodule

FILE: rtl/cts_front.sv
module cts_front
    import cts_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 8,
    parameter int LINE_SHIFT     = 4
)
(
    input  cfg_t                      cfg,
    input  logic [1:0]                cmd,
    input  logic [1:0]                cache_sel,
    input  logic [ADDR_W-1:0]         address,
    input  logic [WORD_W-1:0]         block_in,
    output item_t                     item,
    output logic [MAX_INDEX_BITS-1:0] set_idx
);

    localparam logic [3:0] MAXB = 4'(MAX_INDEX_BITS);

    logic [3:0]                bits_raw;
    logic [3:0]                bits_c;
    logic [MAX_INDEX_BITS-1:0] mask;
    logic [LINE_W-1:0]         line;
    cmd_t                      cmd_c;

    // decode command and cache, unused selector maps to the L1 data cache
    always_comb
    begin
        cmd_c = cmd_t'(cmd);
        case (cache_sel)
            2'd0:    item.cache = CACHE_L1I;
            2'd1:    item.cache = CACHE_L2;
            default: item.cache = CACHE_L1D;
        endcase
        item.cmd = cmd_c;
    end

    // pick the key: line for find, block word otherwise
    always_comb
    begin
        if (cmd_c == CMD_FIND)
        begin
            line     = LINE_W'(address >> LINE_SHIFT);
            item.key = {1'b0, line};
        end
        else
        begin
            line     = block_in[WORD_W-1:1];
            item.key = block_in;
        end
    end

    // clamp index bits and mask the set index
    always_comb
    begin
        bits_raw = (item.cache == CACHE_L2) ? cfg.l2_bits : cfg.l1_bits;
        bits_c   = (bits_raw > MAXB) ? MAXB : bits_raw;
        for (int i = 0; i < MAX_INDEX_BITS; i++)
        begin
            mask[i] = (4'(i) < bits_c);
        end
        set_idx = line[MAX_INDEX_BITS-1:0] & mask;
    end

endmodule

FILE: rtl/cts_fifo.sv
module cts_fifo
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic         pop,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rptr_reg];

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // hold entry data
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

FILE: rtl/cts_back.sv
module cts_back
    import cts_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 8,
    parameter int L2_WAYS        = 4
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      q_empty,
    input  item_t                     q_item,
    input  logic [MAX_INDEX_BITS-1:0] q_set,
    output logic                      q_pop,
    input  logic                      res_full,
    output logic                      res_push,
    output res_t                      res
);

    localparam int NSETS   = 1 << MAX_INDEX_BITS;
    localparam int WAYS_W  = $clog2(L2_WAYS + 1);
    localparam int WIDX_W  = $clog2(L2_WAYS);
    localparam int WORDS_W = L2_WAYS * WORD_W;
    localparam int ROW_W   = WORDS_W + WAYS_W;
    localparam int RECIP_S = 24;
    localparam logic [40:0] RECIP_M = 41'(((1 << RECIP_S) + L2_WAYS - 1) / L2_WAYS);
    localparam logic [WAYS_W-1:0] WAYS_N = WAYS_W'(L2_WAYS);

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        return (s >> 1) ^ (s[0] ? LFSR_TAPS : 16'h0000);
    endfunction

    back_state_t               state_reg;
    back_state_t               state_next;
    item_t                     item_reg;
    logic [MAX_INDEX_BITS-1:0] set_reg;
    logic [MAX_INDEX_BITS-1:0] clr_reg;
    logic [15:0]               lfsr_reg;
    logic [WIDX_W-1:0]         vic_reg;
    logic [ROW_W-1:0]          rd_l2_reg;
    logic [WORD_W:0]           rd_l1i_reg;
    logic [WORD_W:0]           rd_l1d_reg;

    // L2 row: fill count on top of the words; L1 entry: valid bit on top
    logic [ROW_W-1:0]  mem_l2  [NSETS];
    logic [WORD_W:0]   mem_l1i [NSETS];
    logic [WORD_W:0]   mem_l1d [NSETS];

    logic              start;
    logic [15:0]       lfsr_cand;
    logic [40:0]       recip_prod;
    logic [15:0]       recip_quo;
    logic [15:0]       lfsr_mod;
    logic [WIDX_W-1:0] victim;
    logic [WORD_W-1:0] words [L2_WAYS];
    logic [WORD_W-1:0] new_words [L2_WAYS];
    logic [ROW_W-1:0]  new_row;
    logic [WAYS_W-1:0] n;
    logic [WAYS_W-1:0] new_fill;
    logic              hit;
    logic [WIDX_W-1:0] hw;
    logic [WIDX_W-1:0] del;
    logic              do_del;
    logic [WORD_W-1:0] l1_word;
    logic              l1_vld;
    logic              l1_new_vld;
    logic [WORD_W-1:0] l1_new_word;
    logic              full_set;
    logic              lfsr_adv;

    assign start     = (state_reg == B_IDLE) && !q_empty && !res_full;
    assign lfsr_cand = lfsr_step(lfsr_reg);

    // next state
    always_comb
    begin
        case (state_reg)
            B_CLEAR: state_next = (&clr_reg) ? B_IDLE : B_CLEAR;
            B_IDLE:  state_next = start ? B_EXEC : B_IDLE;
            B_EXEC:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        case (state_reg)
            B_IDLE:
            begin
                q_pop    = start;
                res_push = 1'b0;
            end
            B_EXEC:
            begin
                q_pop    = 1'b0;
                res_push = 1'b1;
            end
            default:
            begin
                q_pop    = 1'b0;
                res_push = 1'b0;
            end
        endcase
    end

    // next LFSR value modulo the way count by reciprocal multiplication
    always_comb
    begin
        recip_prod = 41'(lfsr_cand) * RECIP_M;
        recip_quo  = recip_prod[RECIP_S +: 16];
        lfsr_mod   = lfsr_cand - 16'(recip_quo * 16'(L2_WAYS));
        victim     = cfg.policy ? vic_reg : '0;
    end

    // compare and reorder the L2 set
    always_comb
    begin
        n        = rd_l2_reg[WORDS_W +: WAYS_W];
        hit      = 1'b0;
        hw       = '0;
        del      = '0;
        do_del   = 1'b0;
        new_fill = n;
        for (int w = 0; w < L2_WAYS; w++)
        begin
            words[w] = rd_l2_reg[w*WORD_W +: WORD_W];
        end
        for (int w = 0; w < L2_WAYS; w++)
        begin
            if (!hit && (WAYS_W'(w) < n))
            begin
                if (item_reg.cmd == CMD_FIND)
                begin
                    if (words[w][WORD_W-1:1] == item_reg.key[LINE_W-1:0])
                    begin
                        hit = 1'b1;
                        hw  = WIDX_W'(w);
                    end
                end
                else if (words[w] == item_reg.key)
                begin
                    hit = 1'b1;
                    hw  = WIDX_W'(w);
                end
            end
        end
        if (item_reg.cmd == CMD_INSERT && n == WAYS_N)
        begin
            do_del = 1'b1;
            del    = victim;
        end
        else if (item_reg.cmd == CMD_REMOVE && hit)
        begin
            do_del   = 1'b1;
            del      = hw;
            new_fill = n - WAYS_W'(1);
        end
        for (int w = 0; w < L2_WAYS; w++)
        begin
            new_words[w] = words[w];
            if (do_del && (w < L2_WAYS - 1) && (WIDX_W'(w) >= del))
            begin
                new_words[w] = words[(w + 1) % L2_WAYS];
            end
        end
        if (item_reg.cmd == CMD_INSERT)
        begin
            if (n == WAYS_N)
            begin
                new_words[L2_WAYS-1] = item_reg.key;
            end
            else
            begin
                new_words[n[WIDX_W-1:0]] = item_reg.key;
                new_fill                 = n + WAYS_W'(1);
            end
        end
        else if (item_reg.cmd == CMD_MARK && hit)
        begin
            new_words[hw] = item_reg.key | WORD_W'(1);
        end
        for (int w = 0; w < L2_WAYS; w++)
        begin
            new_row[w*WORD_W +: WORD_W] = new_words[w];
        end
        new_row[WORDS_W +: WAYS_W] = new_fill;
    end

    // compare and update the direct-mapped sets
    always_comb
    begin
        if (item_reg.cache == CACHE_L1I)
        begin
            l1_word = rd_l1i_reg[WORD_W-1:0];
            l1_vld  = rd_l1i_reg[WORD_W];
        end
        else
        begin
            l1_word = rd_l1d_reg[WORD_W-1:0];
            l1_vld  = rd_l1d_reg[WORD_W];
        end
        l1_new_word = l1_word;
        l1_new_vld  = l1_vld;
        case (item_reg.cmd)
            CMD_INSERT:
            begin
                l1_new_word = item_reg.key;
                l1_new_vld  = 1'b1;
            end
            CMD_REMOVE:
            begin
                if (l1_vld && l1_word == item_reg.key)
                begin
                    l1_new_vld = 1'b0;
                end
            end
            CMD_MARK:
            begin
                if (l1_vld && l1_word == item_reg.key)
                begin
                    l1_new_word = item_reg.key | WORD_W'(1);
                end
            end
            default:
            begin
                l1_new_word = l1_word;
            end
        endcase
    end

    // form the result
    always_comb
    begin
        res.found     = 1'b0;
        res.block_out = '0;
        res.evicted   = 1'b0;
        if (item_reg.cache == CACHE_L2)
        begin
            full_set = (n == WAYS_N);
            case (item_reg.cmd)
                CMD_FIND:
                begin
                    res.found     = hit;
                    res.block_out = hit ? words[hw] : '0;
                end
                CMD_INSERT:
                begin
                    res.evicted   = full_set;
                    res.block_out = full_set ? words[victim] : '0;
                end
                default:
                begin
                    res.found = hit;
                end
            endcase
        end
        else
        begin
            full_set = l1_vld;
            case (item_reg.cmd)
                CMD_FIND:
                begin
                    res.found     = l1_vld && (l1_word[WORD_W-1:1] ==
                                               item_reg.key[LINE_W-1:0]);
                    res.block_out = res.found ? l1_word : '0;
                end
                CMD_INSERT:
                begin
                    res.evicted   = l1_vld;
                    res.block_out = l1_vld ? l1_word : '0;
                end
                default:
                begin
                    res.found = l1_vld && (l1_word == item_reg.key);
                end
            endcase
        end
        lfsr_adv = (item_reg.cmd == CMD_INSERT) && full_set && cfg.policy;
    end

    // sequencer state, clearing counter and LFSR
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            lfsr_reg  <= LFSR_SEED;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_reg <= clr_reg + MAX_INDEX_BITS'(1);
            end
            if (state_reg == B_EXEC && lfsr_adv)
            begin
                lfsr_reg <= lfsr_cand;
            end
        end
    end

    // latch the item and the candidate victim way
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= q_item;
            set_reg  <= q_set;
            vic_reg  <= WIDX_W'(lfsr_mod);
        end
    end

    // clear the sets after reset, read the set, write it back after compare
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rd_l2_reg  <= mem_l2[q_set];
            rd_l1i_reg <= mem_l1i[q_set];
            rd_l1d_reg <= mem_l1d[q_set];
        end
        if (state_reg == B_CLEAR)
        begin
            mem_l2[clr_reg]  <= '0;
            mem_l1i[clr_reg] <= '0;
            mem_l1d[clr_reg] <= '0;
        end
        else if (state_reg == B_EXEC && item_reg.cmd != CMD_FIND)
        begin
            case (item_reg.cache)
                CACHE_L2:  mem_l2[set_reg]  <= new_row;
                CACHE_L1I: mem_l1i[set_reg] <= {l1_new_vld, l1_new_word};
                default:   mem_l1d[set_reg] <= {l1_new_vld, l1_new_word};
            endcase
        end
    end

endmodule

FILE: rtl/cts_checker.sv
module cts_checker
    import cts_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic              found,
    input logic [WORD_W-1:0] block_out,
    input logic              evicted
);

    logic [2:0] outstanding_reg;

    // track commands transferred but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 3'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 3'((push && !full) ? 1 : 0)
                                               - 3'((pop && !empty) ? 1 : 0);
        end
    end

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> outstanding_reg != 3'd0)
        else $error("result shown with no command outstanding");

    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !evicted && !found) |-> block_out == '0)
        else $error("nonzero block word without hit or eviction");

    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && evicted) |-> !found)
        else $error("eviction flagged together with hit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(block_out) && $stable(found)
                              && $stable(evicted)))
        else $error("stalled result changed");

endmodule

bind cache_tag_store_lru_top cts_checker u_cts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .found     (found),
    .block_out (block_out),
    .evicted   (evicted)
);
